// File: rtl/mrts_pkg.sv
// ----------------------------------------------------------------------------
// mrts_pkg: shared definitions for the multi-rate tick scheduler
// Field widths, register indexes, request codes and the back-end state type.
// ----------------------------------------------------------------------------
package mrts_pkg;

  // fixed field widths of the request, event and config channels
  localparam int NOW_W      = 48;
  localparam int ELAPSED_W  = 48;
  localparam int TICK_W     = 32;
  localparam int CHAN_W     = 2;
  localparam int IVL_W      = 40;
  localparam int CIU_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // default sizes of the internal state
  localparam int DEF_CHANNELS   = 4;
  localparam int DEF_TIME_BITS  = 48;
  localparam int DEF_COUNT_BITS = 32;

  // request function codes
  typedef enum logic {
    FUNC_START  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  // config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL_0      = 3'd0,
    REG_INTERVAL_1      = 3'd1,
    REG_INTERVAL_2      = 3'd2,
    REG_INTERVAL_3      = 3'd3,
    REG_CHANNELS_IN_USE = 3'd4
  } reg_index_t;

  // back-end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

endpackage

// File: rtl/mrts_req_if.sv
// ----------------------------------------------------------------------------
// mrts_req_if: request channel
// Carries start and time-sample requests with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrts_req_if;
  import mrts_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [NOW_W-1:0] now_ns;

  modport source (output valid, output func, output now_ns, input ready);
  modport sink   (input valid, input func, input now_ns, output ready);
endinterface

// File: rtl/mrts_evt_if.sv
// ----------------------------------------------------------------------------
// mrts_evt_if: tick event channel
// Carries one event per channel tick with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrts_evt_if;
  import mrts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAN_W-1:0]    channel;
  logic [ELAPSED_W-1:0] elapsed_ns;
  logic [TICK_W-1:0]    tick_number;
  logic                 last;

  modport source (output valid, output channel, output elapsed_ns, output tick_number,
                  output last, input ready);
  modport sink   (input valid, input channel, input elapsed_ns, input tick_number,
                  input last, output ready);
endinterface

// File: rtl/mrts_queue.sv
// ----------------------------------------------------------------------------
// mrts_queue: two-entry sample queue
// Decouples the request front end from the tick sequencer.
// ----------------------------------------------------------------------------
module mrts_queue #(
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/mrts_front.sv
// ----------------------------------------------------------------------------
// mrts_front: request front end
// Accepts requests, tracks the running flag, loads last-tick times on the
// first start and forwards time samples into the sample queue.
// ----------------------------------------------------------------------------
module mrts_front #(
  parameter int TIME_BITS = mrts_pkg::DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  mrts_req_if.sink             req,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [TIME_BITS-1:0] q_data,
  output logic                 load,
  output logic [TIME_BITS-1:0] load_time
);
  import mrts_pkg::*;

  logic running;
  logic accept;

  assign req.ready = !q_full;
  assign accept    = req.valid && req.ready;

  // classify the accepted request
  assign load      = accept && (req.func == FUNC_START) && !running;
  assign q_push    = accept && (req.func == FUNC_SAMPLE) && running;
  assign q_data    = TIME_BITS'(req.now_ns);
  assign load_time = TIME_BITS'(req.now_ns);

  // running flag, set by the first start
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (load) begin
      running <= 1'b1;
    end
  end

endmodule

// File: rtl/mrts_back.sv
// ----------------------------------------------------------------------------
// mrts_back: tick sequencer
// Compares every active channel against its interval for one sample, then
// emits one event per firing channel in ascending order and updates state.
// ----------------------------------------------------------------------------
module mrts_back #(
  parameter int CHANNELS   = mrts_pkg::DEF_CHANNELS,
  parameter int TIME_BITS  = mrts_pkg::DEF_TIME_BITS,
  parameter int COUNT_BITS = mrts_pkg::DEF_COUNT_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mrts_pkg::IVL_W-1:0] interval [CHANNELS],
  input  logic [mrts_pkg::CIU_W-1:0] channels_in_use,
  input  logic                       load,
  input  logic [TIME_BITS-1:0]       load_time,
  input  logic                       q_empty,
  input  logic [TIME_BITS-1:0]       q_head,
  output logic                       q_pop,
  mrts_evt_if.source                 evt
);
  import mrts_pkg::*;

  localparam int CMP_W = (TIME_BITS > IVL_W) ? TIME_BITS : IVL_W;

  back_state_t           state;
  back_state_t           state_next;

  logic [TIME_BITS-1:0]  last_tick [CHANNELS];
  logic [COUNT_BITS-1:0] tick_count [CHANNELS];
  logic [TIME_BITS-1:0]  elapsed_r [CHANNELS];
  logic [TIME_BITS-1:0]  elapsed_calc [CHANNELS];
  logic [CHANNELS-1:0]   mask;
  logic [CHANNELS-1:0]   mask_calc;
  logic [CHANNELS-1:0]   sel;
  logic [CHANNELS-1:0]   mask_rest;
  logic [TIME_BITS-1:0]  now_r;

  logic [CHAN_W-1:0]     sel_chan;
  logic [TIME_BITS-1:0]  sel_elapsed;
  logic [COUNT_BITS-1:0] sel_count;

  logic                  out_valid;
  logic                  out_free;
  logic                  emit;

  // elapsed time and fire decision for every active channel
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      elapsed_calc[i] = q_head - last_tick[i];
      mask_calc[i]    = (channels_in_use > CIU_W'(i)) &&
                        (CMP_W'(elapsed_calc[i]) > CMP_W'(interval[i]));
    end
  end

  // lowest pending channel and its event fields
  always_comb begin
    sel         = '0;
    sel_chan    = '0;
    sel_elapsed = '0;
    sel_count   = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel      = '0;
        sel[i]   = 1'b1;
        sel_chan = CHAN_W'(i);
      end
    end
    for (int i = 0; i < CHANNELS; i++) begin
      if (sel[i]) begin
        sel_elapsed = elapsed_r[i];
        sel_count   = tick_count[i];
      end
    end
  end

  assign mask_rest = mask & ~sel;
  assign out_free  = !out_valid || evt.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty && (mask_calc != '0)) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free && (mask_rest == '0)) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    case (state)
      BK_IDLE: q_pop = !q_empty;
      BK_EMIT: emit  = out_free;
      default: begin
        q_pop = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  // state register and pending mask
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      mask  <= '0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        mask <= mask_calc;
      end else if (emit) begin
        mask <= mask_rest;
      end
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (q_pop) begin
      now_r <= q_head;
      for (int i = 0; i < CHANNELS; i++) begin
        elapsed_r[i] <= elapsed_calc[i];
      end
    end
  end

  // per-channel last tick time and tick count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_tick[i]  <= '0;
        tick_count[i] <= '0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (load) begin
          last_tick[i] <= load_time;
        end else if (emit && sel[i]) begin
          last_tick[i]  <= now_r;
          tick_count[i] <= tick_count[i] + COUNT_BITS'(1);
        end
      end
    end
  end

  // event output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      evt.channel     <= sel_chan;
      evt.elapsed_ns  <= ELAPSED_W'(sel_elapsed);
      evt.tick_number <= TICK_W'(sel_count);
      evt.last        <= (mask_rest == '0);
    end
  end

  assign evt.valid = out_valid;

endmodule

// File: rtl/multi_rate_tick_scheduler_unit.sv
// ----------------------------------------------------------------------------
// multi_rate_tick_scheduler_unit: multi-channel interval timer
// Timestamp-driven tick scheduler with per-channel intervals and counts.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    func, now_ns
//   evt      out  valid/ready    channel, elapsed_ns, tick_number, last
//   cfg      in   cfg_we         cfg_index, cfg_data (no read-back)
//
// A start request is handled in the front end. A time sample waits in a
// two-entry queue; the sequencer pops it and compares all channels, then
// emits one event per firing channel, up to CHANNELS events per sample; the
// event output register sets the pace under stalls.
// Reset is synchronous and clears the running flag, last-tick times, counts,
// intervals and other registers, and sets one channel in use. A stalled event
// holds; requests keep flowing into the queue until it is full.
// ----------------------------------------------------------------------------
module multi_rate_tick_scheduler_unit #(
  parameter int CHANNELS   = mrts_pkg::DEF_CHANNELS,
  parameter int TIME_BITS  = mrts_pkg::DEF_TIME_BITS,
  parameter int COUNT_BITS = mrts_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  mrts_req_if.sink                        req,
  mrts_evt_if.source                      evt,
  input  logic                            cfg_we,
  input  logic [mrts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mrts_pkg::*;

  logic [IVL_W-1:0]     interval [CHANNELS];
  logic [CIU_W-1:0]     channels_in_use;

  logic                 q_push;
  logic [TIME_BITS-1:0] q_data;
  logic                 q_full;
  logic                 q_pop;
  logic [TIME_BITS-1:0] q_head;
  logic                 q_empty;
  logic                 load;
  logic [TIME_BITS-1:0] load_time;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        interval[i] <= '0;
      end
      channels_in_use <= CIU_W'(1);
    end else if (cfg_we) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (cfg_index == (CFG_IDX_W'(REG_INTERVAL_0) + CFG_IDX_W'(i))) begin
          interval[i] <= IVL_W'(cfg_data);
        end
      end
      if (cfg_index == REG_CHANNELS_IN_USE) begin
        channels_in_use <= CIU_W'(cfg_data);
      end
    end
  end

  // request front end
  mrts_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data),
    .load      (load),
    .load_time (load_time)
  );

  // sample queue
  mrts_queue #(
    .WIDTH (TIME_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // tick sequencer
  mrts_back #(
    .CHANNELS   (CHANNELS),
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .interval        (interval),
    .channels_in_use (channels_in_use),
    .load            (load),
    .load_time       (load_time),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .evt             (evt)
  );

endmodule
